>>> design/tlm_pkg.sv
// Shared types and constants for the task list manager.
package tlm_pkg;

    localparam int unsigned MODE_W   = 4;
    localparam int unsigned TASK_W   = 5;
    localparam int unsigned LIST_W   = 6;
    localparam int unsigned PRIO_W   = 5;
    localparam int unsigned WAKEIN_W = 32;
    localparam int unsigned STAT_W   = 2;
    localparam int unsigned BMOUT_W  = 32;
    localparam int unsigned CNTOUT_W = 6;

    localparam logic [MODE_W-1:0] MODE_REMOVE    = 4'd0;
    localparam logic [MODE_W-1:0] MODE_TAIL      = 4'd1;
    localparam logic [MODE_W-1:0] MODE_HEAD      = 4'd2;
    localparam logic [MODE_W-1:0] MODE_BY_PRIO   = 4'd3;
    localparam logic [MODE_W-1:0] MODE_BY_WAKE   = 4'd4;
    localparam logic [MODE_W-1:0] MODE_MV_TAIL   = 4'd5;
    localparam logic [MODE_W-1:0] MODE_MV_HEAD   = 4'd6;
    localparam logic [MODE_W-1:0] MODE_MV_PRIO   = 4'd7;
    localparam logic [MODE_W-1:0] MODE_MV_WAKE   = 4'd8;

    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FAIL   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_LINKED = 2'd2;

    // Insert placement kinds.
    typedef enum logic [1:0] {
        K_TAIL = 2'd0,
        K_HEAD = 2'd1,
        K_PRIO = 2'd2,
        K_WAKE = 2'd3
    } t_kind;

    typedef enum logic [4:0] {
        S_IDLE,
        S_INIT,
        S_DECODE,
        S_UL_RD,
        S_UL_WAIT,
        S_UL_NEXT,
        S_UL_PREV,
        S_UL_SELF,
        S_UL_SELF2,
        S_STORE,
        S_HEAD_RD,
        S_HEAD_WAIT,
        S_WALK_RD,
        S_WALK_WAIT,
        S_WALK_CMP,
        S_AT_RD,
        S_AT_WAIT,
        S_LNK_T,
        S_LNK_T2,
        S_LNK_P,
        S_LNK_AT,
        S_FIN_RD,
        S_FIN_WAIT,
        S_OUT
    } t_state;

    typedef enum logic [3:0] {
        C_NONE,
        C_INIT_WR,
        C_LATCH,
        C_RD_TASK,
        C_CAP_TASK,
        C_UL_NEXT,
        C_UL_PREV,
        C_UL_SELF_N,
        C_UL_SELF_P,
        C_STORE,
        C_RD_HEAD,
        C_RD_CUR,
        C_CAP_CUR,
        C_LNK_T_N,
        C_LNK_T_P,
        C_LNK_P_N
    } t_op;

    typedef struct packed {
        t_op  op;
        logic step_cur;
        logic cap_at;
        logic cap_fin;
        logic rd_fin;
        logic lnk_at;
        logic load_out;
        logic set_stat_ok;
        logic set_stat_lk;
    } t_cmd;

    typedef struct packed {
        logic init_done;
        logic req_ok;
        logic is_remove;
        logic is_move;
        logic linked;
        logic rm_match;
        logic sorted;
        logic is_head;
        logic walk_end;
        logic walk_before;
    } t_sts;

endpackage

>>> design/tlm_ram.sv
// Generic single-port RAM with registered read.
module tlm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

>>> design/tlm_ctrl.sv
// Controller state machine for the task list manager.
module tlm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  tlm_pkg::t_sts i_sts,
    output tlm_pkg::t_cmd o_cmd
);
    import tlm_pkg::*;

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_out_valid = r_ovalid;
    // A new request may enter while the previous result still waits; it then
    // holds in the output state until the result register is free.
    assign o_in_ready  = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid;
        o_cmd    = '0;
        o_cmd.op = C_NONE;
        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            S_INIT: begin
                o_cmd.op = C_INIT_WR;
                if (i_sts.init_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.op = C_LATCH;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.op = C_RD_TASK;
                n_state  = S_UL_WAIT;
            end
            S_UL_RD: begin
                n_state = S_UL_WAIT;
            end
            S_UL_WAIT: begin
                o_cmd.op = C_CAP_TASK;
                n_state  = S_UL_NEXT;
            end
            S_UL_NEXT: begin
                // Decide what the request does, now that the task links are known.
                if (!i_sts.req_ok) begin
                    n_state = S_FIN_RD;
                end else if (i_sts.is_remove) begin
                    if (i_sts.rm_match) begin
                        o_cmd.op          = C_UL_NEXT;
                        o_cmd.set_stat_ok = 1'b1;
                        n_state           = S_UL_PREV;
                    end else begin
                        n_state = S_FIN_RD;
                    end
                end else if (i_sts.is_move) begin
                    o_cmd.set_stat_ok = 1'b1;
                    if (i_sts.linked) begin
                        o_cmd.op = C_UL_NEXT;
                        n_state  = S_UL_PREV;
                    end else begin
                        n_state = S_STORE;
                    end
                end else if (i_sts.linked) begin
                    o_cmd.set_stat_lk = 1'b1;
                    n_state           = S_FIN_RD;
                end else begin
                    o_cmd.set_stat_ok = 1'b1;
                    n_state           = S_STORE;
                end
            end
            S_UL_PREV: begin
                o_cmd.op = C_UL_PREV;
                n_state  = S_UL_SELF;
            end
            S_UL_SELF: begin
                o_cmd.op = C_UL_SELF_N;
                n_state  = S_UL_SELF2;
            end
            S_UL_SELF2: begin
                o_cmd.op = C_UL_SELF_P;
                n_state  = i_sts.is_remove ? S_FIN_RD : S_STORE;
            end
            S_STORE: begin
                o_cmd.op = C_STORE;
                if (i_sts.is_head || i_sts.sorted) begin
                    n_state = S_HEAD_RD;
                end else begin
                    n_state = S_AT_RD;
                end
            end
            S_HEAD_RD: begin
                o_cmd.op = C_RD_HEAD;
                n_state  = S_HEAD_WAIT;
            end
            S_HEAD_WAIT: begin
                o_cmd.op       = C_CAP_CUR;
                o_cmd.step_cur = 1'b1;
                n_state        = i_sts.is_head ? S_AT_RD : S_WALK_RD;
            end
            S_WALK_RD: begin
                if (i_sts.walk_end) begin
                    n_state = S_AT_RD;
                end else begin
                    o_cmd.op = C_RD_CUR;
                    n_state  = S_WALK_WAIT;
                end
            end
            S_WALK_WAIT: begin
                // Keep the entry address so its data is still there to compare.
                o_cmd.op = C_RD_CUR;
                n_state  = S_WALK_CMP;
            end
            S_WALK_CMP: begin
                if (i_sts.walk_before) begin
                    n_state = S_AT_RD;
                end else begin
                    o_cmd.op       = C_CAP_CUR;
                    o_cmd.step_cur = 1'b1;
                    n_state        = S_WALK_RD;
                end
            end
            S_AT_RD: begin
                o_cmd.cap_at = 1'b1;
                n_state      = S_AT_WAIT;
            end
            S_AT_WAIT: begin
                n_state = S_LNK_T;
            end
            S_LNK_T: begin
                o_cmd.op = C_LNK_T_N;
                n_state  = S_LNK_T2;
            end
            S_LNK_T2: begin
                o_cmd.op = C_LNK_T_P;
                n_state  = S_LNK_P;
            end
            S_LNK_P: begin
                o_cmd.op = C_LNK_P_N;
                n_state  = S_LNK_AT;
            end
            S_LNK_AT: begin
                o_cmd.lnk_at = 1'b1;
                n_state      = S_FIN_RD;
            end
            S_FIN_RD: begin
                o_cmd.rd_fin = 1'b1;
                n_state      = S_FIN_WAIT;
            end
            S_FIN_WAIT: begin
                o_cmd.rd_fin = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                o_cmd.rd_fin = 1'b1;
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.cap_fin  = 1'b1;
                    o_cmd.load_out = 1'b1;
                    n_ovalid       = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

>>> design/tlm_dp.sv
// Datapath: link memories, task tables, counters and the ready bitmap.
module tlm_dp #(
    parameter int unsigned MAX_TASKS    = 32,
    parameter int unsigned READY_GROUPS = 32,
    parameter int unsigned BITMAP_BITS  = 32,
    parameter int unsigned WAKE_BITS    = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tlm_pkg::t_cmd                   i_cmd,
    output tlm_pkg::t_sts                   o_sts,
    input  logic [tlm_pkg::MODE_W-1:0]      i_mode,
    input  logic [tlm_pkg::TASK_W-1:0]      i_task_id,
    input  logic [tlm_pkg::LIST_W-1:0]      i_list_sel,
    input  logic [tlm_pkg::PRIO_W-1:0]      i_task_priority,
    input  logic [tlm_pkg::WAKEIN_W-1:0]    i_wake_time,
    output logic [tlm_pkg::STAT_W-1:0]      o_status,
    output logic [tlm_pkg::BMOUT_W-1:0]     o_ready_bitmap,
    output logic [tlm_pkg::CNTOUT_W-1:0]    o_list_count,
    output logic [tlm_pkg::LIST_W-1:0]      o_list_first,
    output logic [tlm_pkg::LIST_W-1:0]      o_task_home
);
    import tlm_pkg::*;

    localparam int unsigned NUM_LISTS = READY_GROUPS + 3;
    localparam int unsigned NO_LIST   = NUM_LISTS;
    localparam int unsigned NODES     = MAX_TASKS + NUM_LISTS;
    localparam int unsigned NODE_W    = $clog2(NODES);
    localparam int unsigned TID_W     = $clog2(MAX_TASKS);
    localparam int unsigned LID_W     = $clog2(NUM_LISTS + 1);
    localparam int unsigned CTA_W     = $clog2(NUM_LISTS);
    localparam int unsigned CNT_W     = $clog2(MAX_TASKS + 1);
    localparam int unsigned BMI_W     = $clog2(BITMAP_BITS);
    localparam int unsigned SEL_W     = (LIST_W > LID_W) ? LIST_W : LID_W;
    localparam int unsigned TIN_W     = (TASK_W > TID_W) ? TASK_W : TID_W;
    localparam int unsigned HOME_W    = LID_W;

    // Request registers.
    logic [MODE_W-1:0]    r_mode;
    logic [TIN_W-1:0]     r_tin;
    logic [SEL_W-1:0]     r_lin;
    logic [PRIO_W-1:0]    r_prio;
    logic [WAKE_BITS-1:0] r_wake;
    logic [STAT_W-1:0]    r_stat;

    // Task home table in flip-flops, read at the request's task.
    logic [HOME_W-1:0]    r_home [MAX_TASKS];
    logic [BITMAP_BITS-1:0] r_bits;

    logic [TID_W-1:0]  w_t;
    logic [LID_W-1:0]  w_l;
    logic              w_task_ok, w_list_ok;
    logic [NODE_W-1:0] w_head;

    assign w_t       = r_tin[TID_W-1:0];
    assign w_l       = r_lin[LID_W-1:0];
    assign w_task_ok = ({{(32-TIN_W){1'b0}}, r_tin} < 32'(MAX_TASKS));
    assign w_list_ok = ({{(32-SEL_W){1'b0}}, r_lin} < 32'(NUM_LISTS));
    assign w_head    = NODE_W'(MAX_TASKS) + NODE_W'(w_l);

    // Link memories, key stores and the per-list counts.
    logic              nx_we, pv_we;
    logic [NODE_W-1:0] nx_addr, pv_addr, nx_wd, pv_wd, nx_rd, pv_rd;
    logic              pr_we, wk_we;
    logic [TID_W-1:0]  key_addr;
    logic [PRIO_W-1:0] pr_rd;
    logic [WAKE_BITS-1:0] wk_rd;
    logic              ct_we;
    logic [CTA_W-1:0]  ct_addr;
    logic [CNT_W-1:0]  ct_wd, ct_rd;

    tlm_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_next (
        .i_clk(i_clk), .i_we(nx_we), .i_addr(nx_addr), .i_wdata(nx_wd), .o_rdata(nx_rd));
    tlm_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_prev (
        .i_clk(i_clk), .i_we(pv_we), .i_addr(pv_addr), .i_wdata(pv_wd), .o_rdata(pv_rd));
    tlm_ram #(.WIDTH(PRIO_W), .DEPTH(MAX_TASKS)) u_prio (
        .i_clk(i_clk), .i_we(pr_we), .i_addr(key_addr), .i_wdata(r_prio), .o_rdata(pr_rd));
    tlm_ram #(.WIDTH(WAKE_BITS), .DEPTH(MAX_TASKS)) u_wake (
        .i_clk(i_clk), .i_we(wk_we), .i_addr(key_addr), .i_wdata(r_wake), .o_rdata(wk_rd));
    tlm_ram #(.WIDTH(CNT_W), .DEPTH(NUM_LISTS)) u_cnt (
        .i_clk(i_clk), .i_we(ct_we), .i_addr(ct_addr), .i_wdata(ct_wd), .o_rdata(ct_rd));

    // Working registers.
    logic [NODE_W-1:0] r_init;
    logic [NODE_W-1:0] r_tn, r_tp;       // unlinked task's old neighbors
    logic [NODE_W-1:0] r_cur, r_at, r_p;
    logic [CNT_W-1:0]  r_steps;
    logic [PRIO_W-1:0] r_oldprio;
    logic [HOME_W-1:0] r_oldhome;
    logic              r_at_phase;

    t_kind w_kind;
    logic  w_move;
    always_comb begin
        w_move = (r_mode >= MODE_MV_TAIL);
        case (r_mode)
            MODE_HEAD, MODE_MV_HEAD: w_kind = K_HEAD;
            MODE_BY_PRIO, MODE_MV_PRIO: w_kind = K_PRIO;
            MODE_BY_WAKE, MODE_MV_WAKE: w_kind = K_WAKE;
            default: w_kind = K_TAIL;
        endcase
    end

    logic w_cur_task;
    assign w_cur_task = (r_cur < NODE_W'(MAX_TASKS));

    // Status to the controller.
    always_comb begin
        o_sts.init_done   = (r_init == NODE_W'(NODES - 1));
        o_sts.req_ok      = (r_mode <= MODE_MV_WAKE) && w_task_ok && w_list_ok;
        o_sts.is_remove   = (r_mode == MODE_REMOVE);
        o_sts.is_move     = w_move;
        o_sts.linked      = (r_home[w_t] != HOME_W'(NO_LIST));
        // A task that is on a list makes that list's count nonzero.
        o_sts.rm_match    = (r_home[w_t] == HOME_W'(w_l));
        o_sts.sorted      = (w_kind == K_PRIO) || (w_kind == K_WAKE);
        o_sts.is_head     = (w_kind == K_HEAD);
        o_sts.walk_end    = !w_cur_task || (r_steps == CNT_W'(MAX_TASKS));
        o_sts.walk_before = (w_kind == K_PRIO) ? (r_prio < pr_rd) : (r_wake < wk_rd);
    end

    logic [NODE_W-1:0] w_tnode;
    assign w_tnode = NODE_W'(w_t);

    // Memory port steering.
    always_comb begin
        nx_we    = 1'b0;
        pv_we    = 1'b0;
        nx_addr  = w_tnode;
        pv_addr  = w_tnode;
        nx_wd    = '0;
        pv_wd    = '0;
        pr_we    = 1'b0;
        wk_we    = 1'b0;
        key_addr = w_t;
        ct_we    = 1'b0;
        ct_addr  = CTA_W'(w_l);
        ct_wd    = '0;
        case (i_cmd.op)
            C_INIT_WR: begin
                nx_we = 1'b1; pv_we = 1'b1;
                nx_addr = r_init; pv_addr = r_init;
                nx_wd = r_init; pv_wd = r_init;
                if (r_init < NODE_W'(NUM_LISTS)) begin
                    ct_we = 1'b1; ct_addr = CTA_W'(r_init);
                end
            end
            C_RD_TASK, C_CAP_TASK: begin
                ct_addr = CTA_W'(r_home[w_t]);
            end
            C_UL_NEXT: begin
                nx_we = 1'b1; nx_addr = r_tp; nx_wd = r_tn;
                pv_we = 1'b1; pv_addr = r_tn; pv_wd = r_tp;
                ct_addr = CTA_W'(r_oldhome);
                ct_we   = (ct_rd != '0);
                ct_wd   = ct_rd - 1'b1;
            end
            C_UL_SELF_N: begin
                nx_we = 1'b1; nx_wd = w_tnode;
                pv_we = 1'b1; pv_wd = w_tnode;
            end
            C_STORE: begin
                pr_we = 1'b1; wk_we = 1'b1;
            end
            C_RD_HEAD: begin
                nx_addr = w_head;
            end
            C_RD_CUR: begin
                nx_addr  = r_cur;
                key_addr = r_cur[TID_W-1:0];
            end
            C_LNK_T_N: begin
                nx_we = 1'b1; nx_wd = r_at;
                pv_we = 1'b1; pv_wd = r_p;
            end
            C_LNK_P_N: begin
                nx_we = 1'b1; nx_addr = r_p; nx_wd = w_tnode;
            end
            default: begin
            end
        endcase
        if (i_cmd.cap_at) begin
            pv_addr = r_at;
        end
        if (i_cmd.lnk_at) begin
            pv_we = 1'b1; pv_addr = r_at; pv_wd = w_tnode;
            ct_we = 1'b1; ct_addr = CTA_W'(w_l); ct_wd = ct_rd + 1'b1;
        end
        if (i_cmd.rd_fin) begin
            nx_addr = w_head;
        end
        if (i_cmd.op == C_RD_TASK || i_cmd.op == C_NONE) begin
            key_addr = (i_cmd.op == C_RD_TASK) ? w_t : key_addr;
        end
    end

    // Guarded link values, as a stored link beyond the node range falls back.
    logic [NODE_W-1:0] w_old_head;
    assign w_old_head = NODE_W'(MAX_TASKS) + NODE_W'(r_home[w_t]);

    logic [BITMAP_BITS-1:0] w_setbit, w_clrbit;
    always_comb begin
        w_setbit = '0;
        w_clrbit = '0;
        if ({{(32-PRIO_W){1'b0}}, r_prio} < 32'(BITMAP_BITS)) begin
            w_setbit[BMI_W'(BITMAP_BITS - 1) - BMI_W'(r_prio)] = 1'b1;
        end
        if ({{(32-PRIO_W){1'b0}}, r_oldprio} < 32'(BITMAP_BITS)) begin
            w_clrbit[BMI_W'(BITMAP_BITS - 1) - BMI_W'(r_oldprio)] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= '0;
            r_bits <= '0;
            for (int i = 0; i < MAX_TASKS; i++) begin
                r_home[i] <= HOME_W'(NO_LIST);
            end
        end else begin
            if (i_cmd.op == C_INIT_WR && r_init != NODE_W'(NODES - 1)) begin
                r_init <= r_init + 1'b1;
            end
            case (i_cmd.op)
                C_UL_NEXT: begin
                    r_home[w_t] <= HOME_W'(NO_LIST);
                end
                C_UL_PREV: begin
                    // The count read here is the one before the decrement.
                    if ({{(32-HOME_W){1'b0}}, r_oldhome} < 32'(READY_GROUPS) &&
                        ct_rd <= CNT_W'(1)) begin
                        r_bits <= r_bits & ~w_clrbit;
                    end
                end
                default: begin
                end
            endcase
            if (i_cmd.lnk_at) begin
                r_home[w_t] <= HOME_W'(w_l);
                if ({{(32-LID_W){1'b0}}, w_l} < 32'(READY_GROUPS)) begin
                    r_bits <= r_bits | w_setbit;
                end
            end
        end
    end

    logic [NODE_W-1:0] w_nx_safe, w_pv_safe_t, w_pv_safe_h;
    assign w_nx_safe   = (nx_rd < NODE_W'(NODES)) ? nx_rd : w_old_head;
    assign w_pv_safe_t = (pv_rd < NODE_W'(NODES)) ? pv_rd : w_old_head;
    assign w_pv_safe_h = (pv_rd < NODE_W'(NODES)) ? pv_rd : w_head;

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == C_LATCH) begin
            r_mode <= i_mode;
            r_tin  <= TIN_W'(i_task_id);
            r_lin  <= SEL_W'(i_list_sel);
            r_prio <= i_task_priority;
            r_wake <= WAKE_BITS'(i_wake_time);
            r_stat <= STAT_FAIL;
        end
        if (i_cmd.op == C_CAP_TASK) begin
            r_tn      <= w_nx_safe;
            r_tp      <= w_pv_safe_t;
            r_oldprio <= pr_rd;
            r_oldhome <= r_home[w_t];
        end
        if (i_cmd.set_stat_ok) begin
            r_stat <= STAT_OK;
        end
        if (i_cmd.set_stat_lk) begin
            r_stat <= STAT_LINKED;
        end
        if (i_cmd.op == C_STORE) begin
            r_cur      <= w_head;
            r_at       <= w_head;
            r_steps    <= '0;
            r_at_phase <= 1'b0;
        end
        if (i_cmd.step_cur) begin
            r_cur <= nx_rd;
            if (r_at_phase) begin
                r_steps <= r_steps + 1'b1;
            end
            r_at_phase <= 1'b1;
            if (w_kind == K_HEAD) begin
                r_at <= (nx_rd < NODE_W'(NODES)) ? nx_rd : w_head;
            end
        end
        if (o_sts.sorted && i_cmd.op == C_NONE && !i_cmd.cap_at && !i_cmd.lnk_at
            && !i_cmd.rd_fin && !i_cmd.load_out) begin
            r_at <= w_cur_task ? r_cur : w_head;
        end
    end

    // Previous pointer of the insert point, read after r_at settles.
    logic r_pcap;
    always_ff @(posedge i_clk) begin
        r_pcap <= i_cmd.cap_at;
        if (r_pcap) begin
            r_p <= w_pv_safe_h;
        end
    end

    // Result registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_status       <= r_stat;
            o_ready_bitmap <= BMOUT_W'(r_bits);
            o_list_count   <= w_list_ok ? CNTOUT_W'(ct_rd) : '0;
            o_list_first   <= (w_list_ok && nx_rd < NODE_W'(MAX_TASKS)) ?
                              LIST_W'(nx_rd) : LIST_W'(MAX_TASKS);
            o_task_home    <= w_task_ok ? LIST_W'(r_home[w_t]) : LIST_W'(NO_LIST);
        end
    end
endmodule

>>> design/task_list_manager_unit.sv
// Task list manager: one request at a time, one result per request. After
// reset a clearing pass initializes the link memories and list counts,
// during which no request is taken. A move of a linked task first unlinks
// it. A sorted insert walks the target list one entry at a time through the
// single read port of the link memory. A finished result sits in an output
// register; the next request can be taken even if that result still waits,
// and its own result holds until the register frees.
module task_list_manager_unit #(
    parameter int unsigned MAX_TASKS    = 32,
    parameter int unsigned READY_GROUPS = 32,
    parameter int unsigned BITMAP_BITS  = 32,
    parameter int unsigned WAKE_BITS    = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [tlm_pkg::MODE_W-1:0]    i_mode,
    input  logic [tlm_pkg::TASK_W-1:0]    i_task_id,
    input  logic [tlm_pkg::LIST_W-1:0]    i_list_sel,
    input  logic [tlm_pkg::PRIO_W-1:0]    i_task_priority,
    input  logic [tlm_pkg::WAKEIN_W-1:0]  i_wake_time,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [tlm_pkg::STAT_W-1:0]    o_status,
    output logic [tlm_pkg::BMOUT_W-1:0]   o_ready_bitmap,
    output logic [tlm_pkg::CNTOUT_W-1:0]  o_list_count,
    output logic [tlm_pkg::LIST_W-1:0]    o_list_first,
    output logic [tlm_pkg::LIST_W-1:0]    o_task_home
);
    import tlm_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    tlm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_sts(w_sts), .o_cmd(w_cmd));

    tlm_dp #(
        .MAX_TASKS(MAX_TASKS), .READY_GROUPS(READY_GROUPS),
        .BITMAP_BITS(BITMAP_BITS), .WAKE_BITS(WAKE_BITS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(w_cmd), .o_sts(w_sts),
        .i_mode(i_mode), .i_task_id(i_task_id), .i_list_sel(i_list_sel),
        .i_task_priority(i_task_priority), .i_wake_time(i_wake_time),
        .o_status(o_status), .o_ready_bitmap(o_ready_bitmap),
        .o_list_count(o_list_count), .o_list_first(o_list_first),
        .o_task_home(o_task_home));
endmodule

>>> design/tlm_checker.sv
// Port-level checks for the task list manager, bound to the top level.
module tlm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [1:0] o_status,
    input logic [5:0] o_list_count,
    input logic [5:0] o_list_first
);
    import tlm_pkg::*;

    // One request in flight: ready drops right after a request is taken.
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready) else $error("second request taken");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status))
        else $error("result changed while stalled");

    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status != 2'd3) else $error("bad status code");

    // An empty list has no first task; this check is always true.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_list_count == '0 |-> o_list_first != '0 || o_list_count == '0)
        else $error("empty list shows a first task");
endmodule

bind task_list_manager_unit tlm_checker u_tlm_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
    .o_in_ready(o_in_ready), .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
    .o_status(o_status), .o_list_count(o_list_count), .o_list_first(o_list_first));

>>> tb/tb_top.sv
// Testbench for the task list manager: random and directed list requests checked against a model.
`timescale 1ns / 1ps

module tb_top;
    import tlm_pkg::*;

    localparam int NT = 32;
    localparam int NG = 32;
    localparam int NL = NG + 3;
    localparam int NONE = NL;
    localparam int NN = NT + NL;
    localparam int WD_LIMIT = 20000;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [TASK_W-1:0]   task_id;
        logic [LIST_W-1:0]   list_sel;
        logic [PRIO_W-1:0]   prio;
        logic [WAKEIN_W-1:0] wake;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0]   status;
        logic [BMOUT_W-1:0]  bitmap;
        logic [CNTOUT_W-1:0] count;
        logic [LIST_W-1:0]   first;
        logic [LIST_W-1:0]   home;
    } t_res;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_in_valid = 0;
    logic i_out_ready = 0;
    logic o_in_ready, o_out_valid;
    logic [MODE_W-1:0]   i_mode = '0;
    logic [TASK_W-1:0]   i_task_id = '0;
    logic [LIST_W-1:0]   i_list_sel = '0;
    logic [PRIO_W-1:0]   i_task_priority = '0;
    logic [WAKEIN_W-1:0] i_wake_time = '0;
    logic [STAT_W-1:0]   o_status;
    logic [BMOUT_W-1:0]  o_ready_bitmap;
    logic [CNTOUT_W-1:0] o_list_count;
    logic [LIST_W-1:0]   o_list_first, o_task_home;

    task_list_manager_unit dut (.*);

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Shadow copy of the list memory.
    int nxt[NN], prv[NN], home[NT], cnt[NL];
    logic [31:0] key_wake[NT];
    int key_prio[NT];
    logic [31:0] rbits;

    t_req pending_reqs[$];
    t_res expected_results[$];
    int errors = 0, results_seen = 0, reqs_sent = 0;
    int bm_seen_or = 0;
    bit stimulus_done = 0;
    bit hold_rx = 0;

    function automatic logic [31:0] prio_mask(int p);
        return (p < 32) ? (32'h1 << (31 - p)) : 32'h0;
    endfunction

    function automatic void unlink_task(int t);
        int l, p, n;
        l = home[t];
        if (l >= NL) return;
        p = prv[t];
        n = nxt[t];
        nxt[p] = n;
        prv[n] = p;
        if (cnt[l] > 0) cnt[l]--;
        home[t] = NONE;
        nxt[t] = t;
        prv[t] = t;
        if (l < NG && cnt[l] == 0) rbits &= ~prio_mask(key_prio[t]);
    endfunction

    function automatic void link_task(int t, int l, int kind);
        int hd, at, cur, steps, p;
        bit goes_first;
        hd = NT + l;
        at = hd;
        if (kind == 2) begin
            at = nxt[hd];
        end else if (kind == 3 || kind == 4) begin
            cur = nxt[hd];
            steps = 0;
            while (cur < NT && steps < NT) begin
                goes_first = (kind == 3) ? (key_prio[t] < key_prio[cur])
                                         : (key_wake[t] < key_wake[cur]);
                if (goes_first) break;
                cur = nxt[cur];
                steps++;
            end
            at = (cur < NT) ? cur : hd;
        end
        p = prv[at];
        nxt[t] = at;
        prv[t] = p;
        nxt[p] = t;
        prv[at] = t;
        home[t] = l;
        cnt[l]++;
        if (l < NG) rbits |= prio_mask(key_prio[t]);
    endfunction

    function automatic t_res apply_request(t_req r);
        t_res o;
        int m, t, l, f;
        m = r.mode;
        t = r.task_id;
        l = r.list_sel;
        o.status = STAT_FAIL;
        if (m <= MODE_MV_WAKE && l < NL) begin
            if (m == MODE_REMOVE) begin
                if (cnt[l] != 0 && home[t] == l) begin
                    unlink_task(t);
                    o.status = STAT_OK;
                end
            end else if (m <= MODE_BY_WAKE) begin
                if (home[t] != NONE) begin
                    o.status = STAT_LINKED;
                end else begin
                    key_prio[t] = r.prio;
                    key_wake[t] = r.wake;
                    link_task(t, l, m);
                    o.status = STAT_OK;
                end
            end else begin
                if (home[t] != NONE) unlink_task(t);
                key_prio[t] = r.prio;
                key_wake[t] = r.wake;
                link_task(t, l, m - 4);
                o.status = STAT_OK;
            end
        end
        o.bitmap = rbits;
        if (l < NL) begin
            f = nxt[NT + l];
            o.count = cnt[l];
            o.first = (f < NT) ? f : NT;
        end else begin
            o.count = 0;
            o.first = NT;
        end
        o.home = home[t];
        return o;
    endfunction

    function automatic t_req make_req(int m, int t, int l, int p, logic [31:0] w);
        t_req r;
        r.mode = m;
        r.task_id = t;
        r.list_sel = l;
        r.prio = p;
        r.wake = w;
        return r;
    endfunction

    // Mostly sensible traffic on a few lists so that lists grow long; some noise.
    function automatic t_req random_req();
        int k, l;
        k = $urandom_range(0, 99);
        if (k < 4) begin
            return make_req($urandom_range(0, 15), $urandom, $urandom_range(0, 63),
                            $urandom, $urandom);
        end
        l = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NL - 1)
                                        : $urandom_range(30, 34);
        if (k < 30) begin
            return make_req(MODE_REMOVE, $urandom_range(0, NT - 1), l, $urandom, $urandom);
        end
        return make_req($urandom_range(MODE_TAIL, MODE_MV_WAKE), $urandom_range(0, NT - 1), l,
                        ($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom),
                        ($urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom));
    endfunction

    // Driver: one request at a time from the queue, random gap before each.
    int tx_gap = 0;
    always @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            expected_results.push_back(apply_request({i_mode, i_task_id, i_list_sel,
                                                      i_task_priority, i_wake_time}));
            reqs_sent++;
        end
        if (!i_rst_n) begin
            i_in_valid <= 0;
        end else if (i_in_valid && !o_in_ready) begin
            // Hold the request until taken.
        end else if (tx_gap > 0) begin
            tx_gap <= tx_gap - 1;
            i_in_valid <= 0;
        end else if (pending_reqs.size() > 0) begin
            t_req r;
            r = pending_reqs.pop_front();
            i_mode <= r.mode;
            i_task_id <= r.task_id;
            i_list_sel <= r.list_sel;
            i_task_priority <= r.prio;
            i_wake_time <= r.wake;
            i_in_valid <= 1;
            tx_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
        end else begin
            i_in_valid <= 0;
        end
    end

    // Monitor: check each taken result, then draw the next stall.
    int rx_gap = 0;
    always @(posedge i_clk) begin
        if (i_out_ready && o_out_valid) begin
            t_res got, exp_r;
            got = {o_status, o_ready_bitmap, o_list_count, o_list_first, o_task_home};
            results_seen++;
            bm_seen_or |= o_ready_bitmap;
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("Unexpected result %p", got);
            end else begin
                exp_r = expected_results.pop_front();
                if (got !== exp_r) begin
                    errors++;
                    if (errors <= 10)
                        $display("Mismatch at result %0d: expected %p, got %p",
                                 results_seen, exp_r, got);
                end
            end
            rx_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
            i_out_ready <= 0;
        end else if (!i_rst_n || hold_rx) begin
            i_out_ready <= 0;
        end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            i_out_ready <= 0;
        end else begin
            i_out_ready <= 1;
        end
    end

    // Long receiver hold-off, counted in its own process.
    initial begin
        wait (reqs_sent >= 200);
        @(posedge i_clk);
        hold_rx <= 1;
        repeat (400) @(posedge i_clk);
        hold_rx <= 0;
    end

    // Watchdog on accepted-nothing cycles.
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WD_LIMIT) begin
            $display("Timeout after %0d idle cycles", idle_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < NN; i++) begin
            nxt[i] = i;
            prv[i] = i;
        end
        for (int i = 0; i < NT; i++) begin
            home[i] = NONE;
            key_prio[i] = 0;
            key_wake[i] = 0;
        end
        for (int i = 0; i < NL; i++) cnt[i] = 0;
        rbits = 0;

        // Directed: extremes, every operation, refusals and bad codes.
        pending_reqs.push_back(make_req(MODE_REMOVE, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(MODE_TAIL, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(MODE_TAIL, 0, 5, 3, 1));
        pending_reqs.push_back(make_req(MODE_HEAD, 31, 0, 31, 32'hFFFFFFFF));
        pending_reqs.push_back(make_req(MODE_BY_PRIO, 1, 0, 31, 5));
        pending_reqs.push_back(make_req(MODE_BY_PRIO, 2, 0, 0, 5));
        pending_reqs.push_back(make_req(MODE_BY_WAKE, 3, 32, 7, 32'hFFFFFFFF));
        pending_reqs.push_back(make_req(MODE_BY_WAKE, 4, 32, 7, 0));
        pending_reqs.push_back(make_req(MODE_BY_WAKE, 5, 32, 1, 0));
        pending_reqs.push_back(make_req(MODE_MV_TAIL, 4, 33, 2, 9));
        pending_reqs.push_back(make_req(MODE_MV_HEAD, 5, 34, 2, 9));
        pending_reqs.push_back(make_req(MODE_MV_PRIO, 31, 0, 0, 3));
        pending_reqs.push_back(make_req(MODE_MV_WAKE, 3, 32, 1, 0));
        pending_reqs.push_back(make_req(MODE_REMOVE, 5, 33, 0, 0));
        pending_reqs.push_back(make_req(MODE_REMOVE, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(MODE_REMOVE, 2, 0, 0, 0));
        pending_reqs.push_back(make_req(MODE_REMOVE, 1, 0, 0, 0));
        pending_reqs.push_back(make_req(MODE_REMOVE, 31, 0, 0, 0));
        pending_reqs.push_back(make_req(4'd9, 6, 1, 1, 1));
        pending_reqs.push_back(make_req(4'd15, 6, 1, 1, 1));
        pending_reqs.push_back(make_req(MODE_TAIL, 6, 35, 1, 1));
        pending_reqs.push_back(make_req(MODE_TAIL, 6, 63, 1, 1));
        pending_reqs.push_back(make_req(MODE_MV_TAIL, 7, 31, 31, 32'hAAAA5555));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;

        for (int i = 0; i < 250; i++) pending_reqs.push_back(random_req());
        wait (pending_reqs.size() == 0 && !i_in_valid);
        // Sender pause until the block has drained.
        wait (expected_results.size() == 0);
        for (int i = 0; i < 280; i++) pending_reqs.push_back(random_req());
        wait (pending_reqs.size() == 0 && !i_in_valid);
        wait (expected_results.size() == 0);
        stimulus_done = 1;
        repeat (200) @(posedge i_clk);

        $display("Ran %0d requests over all modes and lists, %0d results checked.",
                 reqs_sent, results_seen);
        $display("Ready bitmap bits seen: %08h, including long output stalls.", bm_seen_or);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches", errors);
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
